@@ sv/bb3_pkg.sv @@
package bb3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int QDEPTH = 2;
	localparam int RECIP_SHIFT = 17;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	localparam int J_UL = 0;  // row r-1, col c-1
	localparam int J_UR = 1;  // row r-1, col c
	localparam int J_LL = 2;  // row r, col c-1
	localparam int J_LR = 3;  // row r, col c

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [15:0] out_row;
		logic [9:0]  out_col;
		logic        run_last;
		logic        frame_done;
	} result_t;

	typedef pixel_t [2:0][2:0] window_t;

	typedef struct packed {
		logic [10:0] width;
		logic [15:0] height;
		logic        restart;
	} cfg_t;

	typedef struct packed {
		window_t     win;
		logic [3:0]  jobs;
		logic [15:0] row;
		logic [9:0]  col;
		logic        r_ge1;
		logic        r_ge2;
		logic        c_ge1;
		logic        c_ge2;
	} job_rec_t;

	// ceil(2^17 / (2*cnt)), exact for every dividend the blur can produce
	function automatic logic [16:0] recip(input logic [3:0] cnt);
		logic [16:0] m;
		case (cnt)
			4'd1: m = 17'd65536;
			4'd2: m = 17'd32768;
			4'd3: m = 17'd21846;
			4'd4: m = 17'd16384;
			4'd5: m = 17'd13108;
			4'd6: m = 17'd10923;
			4'd7: m = 17'd9363;
			4'd8: m = 17'd8192;
			4'd9: m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

@@ sv/bb3_front.sv @@
module bb3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bb3_pkg::cfg_t       cfg,
	input  bb3_pkg::pixel_t     pixel,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  logic                q_full,
	output logic                push,
	output bb3_pkg::job_rec_t   push_rec
);

	logic [15:0] row_q;
	logic [9:0]  col_q;
	logic        accept;
	logic        lastcol, lastrow;

	bb3_pkg::pixel_t bank0 [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pixel_t bank1 [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pixel_t rd0_q, rd1_q;

	logic            v_s1;
	bb3_pkg::pixel_t pix_s1;
	logic [15:0]     row_s1;
	logic [9:0]      col_s1;
	logic            lastcol_s1, lastrow_s1;

	bb3_pkg::window_t win_q, win_n;
	bb3_pkg::pixel_t  above1, above2;
	logic [3:0]       jobs;
	logic             fire;

	assign lastcol = ({1'b0, col_q} == (cfg.width - 11'd1));
	assign lastrow = (row_q == (cfg.height - 16'd1));
	assign accept  = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (lastcol) begin
				col_q <= '0;
				row_q <= lastrow ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	// line buffers, one per row parity, read before write
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_q <= bank0[col_q[bb3_pkg::AW-1:0]];
			if (!row_q[0]) bank0[col_q[bb3_pkg::AW-1:0]] <= pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd1_q <= bank1[col_q[bb3_pkg::AW-1:0]];
			if (row_q[0]) bank1[col_q[bb3_pkg::AW-1:0]] <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (accept) v_s1 <= 1'b1;
		else if (fire) v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel;
			row_s1     <= row_q;
			col_s1     <= col_q;
			lastcol_s1 <= lastcol;
			lastrow_s1 <= lastrow;
		end
	end

	assign above2 = row_s1[0] ? rd1_q : rd0_q;
	assign above1 = row_s1[0] ? rd0_q : rd1_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_n[k][0] = win_q[k][1];
			win_n[k][1] = win_q[k][2];
		end
		win_n[0][2] = above2;
		win_n[1][2] = above1;
		win_n[2][2] = pix_s1;
	end

	assign jobs[bb3_pkg::J_UL] = (row_s1 != 16'd0) && (col_s1 != 10'd0);
	assign jobs[bb3_pkg::J_UR] = (row_s1 != 16'd0) && lastcol_s1;
	assign jobs[bb3_pkg::J_LL] = lastrow_s1 && (col_s1 != 10'd0);
	assign jobs[bb3_pkg::J_LR] = lastrow_s1 && lastcol_s1;

	assign fire        = v_s1 && (!q_full || (jobs == 4'd0));
	assign pixel_ready = !v_s1 || fire;
	assign push        = fire && (jobs != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) win_q <= '0;
		else if (fire) win_q <= win_n;
	end

	always_comb begin
		push_rec.win   = win_n;
		push_rec.jobs  = jobs;
		push_rec.row   = row_s1;
		push_rec.col   = col_s1;
		push_rec.r_ge1 = (row_s1 != 16'd0);
		push_rec.r_ge2 = (row_s1 > 16'd1);
		push_rec.c_ge1 = (col_s1 != 10'd0);
		push_rec.c_ge2 = (col_s1 > 10'd1);
	end

endmodule

@@ sv/bb3_queue.sv @@
module bb3_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bb3_pkg::job_rec_t push_rec,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output bb3_pkg::job_rec_t head
);

	localparam int PW = (bb3_pkg::QDEPTH > 1) ? $clog2(bb3_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(bb3_pkg::QDEPTH + 1);

	bb3_pkg::job_rec_t slots_q [bb3_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(bb3_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wp_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(bb3_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop) rp_q <= (rp_q == PW'(bb3_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count lost a write");
`endif

endmodule

@@ sv/bb3_back.sv @@
module bb3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bb3_pkg::job_rec_t head,
	output logic              pop,
	output bb3_pkg::result_t  result,
	output logic              result_valid,
	input  logic              result_ready
);

	logic [3:0] taken_q, remaining, sel;
	logic       take, last, adv1, adv2;
	logic       prow, pcol;
	logic [2:0] rmask, cmask;
	logic [11:0] sr, sg, sb;
	logic [3:0]  cnt;

	logic        v_s1;
	logic [12:0] xr_s1, xg_s1, xb_s1;
	logic [3:0]  cnt_s1;
	logic [15:0] row_s1;
	logic [9:0]  col_s1;
	logic        last_s1, done_s1;

	logic [16:0] m;
	logic [29:0] pr, pg, pb;

	assign remaining = head.jobs & ~taken_q;
	assign sel       = remaining & (~remaining + 4'd1);
	assign last      = ((remaining & ~sel) == 4'd0);

	assign adv2 = !result_valid || result_ready;
	assign adv1 = !v_s1 || adv2;
	assign take = head_valid && adv1;
	assign pop  = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) taken_q <= '0;
		else if (pop) taken_q <= '0;
		else if (take) taken_q <= taken_q | sel;
	end

	// which output of the four: upper row and/or left column of the window
	assign prow  = sel[bb3_pkg::J_UL] || sel[bb3_pkg::J_UR];
	assign pcol  = sel[bb3_pkg::J_UL] || sel[bb3_pkg::J_LL];
	assign rmask = prow ? {1'b1, 1'b1, head.r_ge2} : {1'b1, head.r_ge1, 1'b0};
	assign cmask = pcol ? {1'b1, 1'b1, head.c_ge2} : {1'b1, head.c_ge1, 1'b0};

	always_comb begin
		sr  = '0;
		sg  = '0;
		sb  = '0;
		cnt = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (rmask[i] && cmask[j]) begin
					sr  = sr + 12'(head.win[i][j].red);
					sg  = sg + 12'(head.win[i][j].green);
					sb  = sb + 12'(head.win[i][j].blue);
					cnt = cnt + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			xr_s1   <= {sr, 1'b0} + 13'(cnt);
			xg_s1   <= {sg, 1'b0} + 13'(cnt);
			xb_s1   <= {sb, 1'b0} + 13'(cnt);
			cnt_s1  <= cnt;
			row_s1  <= prow ? head.row - 16'd1 : head.row;
			col_s1  <= pcol ? head.col - 10'd1 : head.col;
			last_s1 <= last;
			done_s1 <= sel[bb3_pkg::J_LR];
		end
	end

	// rounded mean by reciprocal multiply
	assign m  = bb3_pkg::recip(cnt_s1);
	assign pr = 30'(xr_s1) * 30'(m);
	assign pg = 30'(xg_s1) * 30'(m);
	assign pb = 30'(xb_s1) * 30'(m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else if (adv2) result_valid <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			result.out_red    <= pr[bb3_pkg::RECIP_SHIFT +: 8];
			result.out_green  <= pg[bb3_pkg::RECIP_SHIFT +: 8];
			result.out_blue   <= pb[bb3_pkg::RECIP_SHIFT +: 8];
			result.out_row    <= row_s1;
			result.out_col    <= col_s1;
			result.run_last   <= last_s1;
			result.frame_done <= done_s1;
		end
	end

endmodule

@@ sv/box_blur_3x3_edge_average.sv @@
// 3x3 box blur over an RGB raster stream, neighbours outside the image left out of the
// mean. One pixel is taken per clock while the result side keeps up; each pixel yields
// 0 to 4 results, one per clock at most through the back end's single sum and multiply
// path, so the long-run input rate is one pixel per clock for rows inside the image and
// slows on the last column and last row, where extra results are produced. Results
// pass the front, queue, back and output registers. Line buffers are not cleared;
// program width and height only while idle, and each write restarts the frame at row 0.
module box_blur_3x3_edge_average (
	input  logic              clk,
	input  logic              arst_n,
	input  bb3_pkg::pixel_t   pixel,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	output bb3_pkg::result_t  result,
	output logic              result_valid,
	input  logic              result_ready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	bb3_pkg::cfg_t cfg;

	logic              push, q_full, pop, head_valid;
	bb3_pkg::job_rec_t push_rec, head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = {1'b0, paddr[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 16'd1;
		end else if (wr_en) begin
			case (reg_idx)
				bb3_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
				bb3_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bb3_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
			bb3_pkg::REG_HEIGHT: prdata = {16'd0, height_q};
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == 11'd0) cfg.width = 11'd1;
		else if (width_q > 11'(bb3_pkg::MAX_WIDTH)) cfg.width = 11'(bb3_pkg::MAX_WIDTH);
		else cfg.width = width_q;
		cfg.height  = (height_q == 16'd0) ? 16'd1 : height_q;
		cfg.restart = wr_en;
	end

	bb3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.q_full      (q_full),
		.push        (push),
		.push_rec    (push_rec)
	);

	bb3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bb3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
